FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// pre at one edge implies post at the next
`define ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/rbb_pkg.sv
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types and constants of the RGB 3x3 box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int CFG_W   = 12;
   localparam int ROW_W   = 12;
   localparam int CNT_W   = 22;
   localparam int SUM_W   = 12;
   localparam int DIM_MAX = 2048;

   localparam logic [CFG_W-1:0] DIM_MIN    = 12'd3;
   localparam logic [CFG_W-1:0] HEIGHT_TOP = 12'd2048;
   localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
   localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;
   localparam logic [ROW_W-1:0] ROW_SAT    = 12'hFFF;

   localparam logic [0:0] CSR_IDX_WIDTH  = 1'b0;
   localparam logic [0:0] CSR_IDX_HEIGHT = 1'b1;

   typedef struct packed {
      logic emit;
      logic border;
      logic frame_end;
   } scan_info_type;

   typedef logic [2:0][SUM_W-1:0] sum_vec_type;

endpackage

FILE: rtl/rgb_box_blur_3x3.sv
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// Streaming 3x3 box blur on raster-order RGB pixels, border pixels pass.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | tdata {red,green,blue}, tuser flush
//  rsp     | out | rsp_tvalid/tready   | tdata {red,green,blue}, tlast end
//  csr     | in  | csr_wr_en           | csr_index, csr_wdata
//
// One request per cycle while nothing stalls; a result passes the registered
// stages scan/RAM read, window, sums and divide by 9 into output register.
// After reset a clearing pass zeroes the line RAM, min(MAX_WIDTH,2048)
// entries, req_tready low. A size write holds req_tready low in the following cycle.
// rsp_tready low stalls the pipe stage by stage back to req_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rgb_box_blur_3x3 #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [0:0]                 csr_index,
   input  logic [rbb_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [rbb_pkg::PIX_W-1:0]  req_tdata,  // blue, green, red
   input  logic                       req_tuser,  // flush
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [rbb_pkg::PIX_W-1:0]  rsp_tdata,  // blue, green, red
   output logic                       rsp_tlast   // frame end
);
   import rbb_pkg::*;

   localparam int DEPTH  = (MAX_WIDTH < DIM_MAX) ? MAX_WIDTH : DIM_MAX;
   localparam int AW     = $clog2(DEPTH);
   localparam int LINE_W = 2 * PIX_W;
   localparam logic [12:0] RECIP_9 = 13'd7282;

   function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
      logic [24:0] p;
      p = 25'(s) * 25'(RECIP_9);
      return p[23:16];
   endfunction

   // clearing pass
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   // scan
   logic          accept, cfg_busy;
   logic [AW-1:0] scan_col;
   scan_info_type scan_info;

   // stage 1
   logic              s1_v_ff, s1_byp_ff;
   logic [PIX_W-1:0]  s1_px_ff;
   logic [AW-1:0]     s1_col_ff;
   scan_info_type     s1_info_ff;
   logic [LINE_W-1:0] s1_byp_data_ff;

   // stage 2 (window)
   logic              s2_v_ff;
   scan_info_type     s2_info_ff;

   // stage 3 (sums)
   logic              s3_v_ff, s3_border_ff, s3_fe_ff;
   sum_vec_type       s3_sum_ff;
   logic [PIX_W-1:0]  s3_center_ff;

   // output
   logic              rsp_v_ff, rsp_last_ff;
   logic [PIX_W-1:0]  rsp_data_ff;

   logic rsp_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;

   logic [PIX_W-1:0]  px_in;
   logic [LINE_W-1:0] ram_rd, line_rd, line_wr, ram_wdata;
   logic [AW-1:0]     ram_waddr;
   logic              ram_we;
   logic [PIX_W-1:0]  win_center;
   sum_vec_type       win_sums;
   logic [PIX_W-1:0]  mean_px;

   assign rsp_free = !rsp_v_ff || rsp_tready;
   assign s3_go    = s3_v_ff && rsp_free;
   assign s3_free  = !s3_v_ff || rsp_free;
   assign s2_go    = s2_v_ff && s3_free;
   assign s2_free  = !s2_v_ff || s3_free;
   assign s1_go    = s1_v_ff && s2_free;
   assign s1_free  = !s1_v_ff || s2_free;

   assign req_tready = s1_free && !clearing_ff && !cfg_busy;
   assign accept     = req_tvalid && req_tready;
   assign px_in      = req_tuser ? '0 : req_tdata;

   rbb_scan #(.DEPTH(DEPTH)) u_scan (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (accept),
      .col       (scan_col),
      .info      (scan_info),
      .cfg_busy  (cfg_busy)
   );

   // line RAM entry: {upper row, middle row}
   assign line_rd = s1_byp_ff ? s1_byp_data_ff : ram_rd;
   assign line_wr = {line_rd[PIX_W-1:0], s1_px_ff};

   always_comb begin
      ram_we    = clearing_ff || s1_go;
      ram_waddr = clearing_ff ? clr_addr_ff : s1_col_ff;
      ram_wdata = clearing_ff ? '0 : line_wr;
   end

   rbb_ram #(.WIDTH(LINE_W), .DEPTH(DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (scan_col),
      .rd_data (ram_rd)
   );

   rbb_window u_window (
      .clock     (clock),
      .reset     (reset),
      .shift_en  (s1_go),
      .upper_px  (line_rd[LINE_W-1:PIX_W]),
      .middle_px (line_rd[PIX_W-1:0]),
      .lower_px  (s1_px_ff),
      .center    (win_center),
      .sums      (win_sums)
   );

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         mean_px[ch*CH_W +: CH_W] = div9(s3_sum_ff[ch]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         rsp_v_ff    <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (clr_addr_ff == AW'(DEPTH - 1)) clearing_ff <= 1'b0;
         end
         if (s1_free) s1_v_ff <= accept;
         if (s2_free) s2_v_ff <= s1_go;
         if (s3_free) s3_v_ff <= s2_go && s2_info_ff.emit;
         if (rsp_free) rsp_v_ff <= s3_go;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_px_ff       <= px_in;
         s1_col_ff      <= scan_col;
         s1_info_ff     <= scan_info;
         s1_byp_ff      <= s1_go && (s1_col_ff == scan_col);
         s1_byp_data_ff <= line_wr;
      end
      if (s1_go) begin
         s2_info_ff <= s1_info_ff;
      end
      if (s2_go) begin
         s3_sum_ff    <= win_sums;
         s3_center_ff <= win_center;
         s3_border_ff <= s2_info_ff.border;
         s3_fe_ff     <= s2_info_ff.frame_end;
      end
      if (s3_go) begin
         rsp_data_ff <= s3_border_ff ? s3_center_ff : mean_px;
         rsp_last_ff <= s3_fe_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   `ASSERT_ALWAYS(a_no_pipe_in_clear, clock, reset, !(clearing_ff && (s1_v_ff || s2_v_ff)), "request in pipe during RAM clear")
   `ASSERT_NEXT(a_cfg_blocks_req, clock, reset, csr_wr_en, !req_tready, "request taken right after size write")
   `ASSERT_NEXT(a_emit_reaches_s3, clock, reset, s2_go && s2_info_ff.emit, s3_v_ff, "emitting request lost after window stage")

endmodule

FILE: rtl/rbb_ram.sv
// ----------------------------------------------------------------------------
// rbb_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rbb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 2048,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rbb_scan.sv
// ----------------------------------------------------------------------------
// rbb_scan
// Size registers and raster position tracking; classifies each request
// (emit, border, frame end) and picks its line buffer column.
// ----------------------------------------------------------------------------
module rbb_scan #(
   parameter int DEPTH = 2048,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_wr_en,
   input  logic [0:0]                 csr_index,
   input  logic [rbb_pkg::CFG_W-1:0]  csr_wdata,
   input  logic                       accept,
   output logic [AW-1:0]              col,
   output rbb_pkg::scan_info_type     info,
   output logic                       cfg_busy
);
   import rbb_pkg::*;

   localparam logic [CFG_W-1:0] WIDTH_TOP = CFG_W'(DEPTH);

   logic [CFG_W-1:0] width_ff, height_ff;
   logic [CFG_W-1:0] eff_w, eff_h;
   logic [CNT_W-1:0] area_ff, area_in;
   logic [2*CFG_W-1:0] area_prod;
   logic             busy_ff;

   logic [AW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             wrap, wrap2;
   logic [AW-1:0]    c;
   logic [CFG_W-1:0] c_ext, c_next;
   logic [ROW_W-1:0] r, r_next, orow;
   logic [CFG_W-1:0] ocol;
   logic             emit, border, fe;

   always_comb begin
      eff_w = width_ff;
      if (width_ff < DIM_MIN) eff_w = DIM_MIN;
      else if (width_ff > WIDTH_TOP) eff_w = WIDTH_TOP;
      eff_h = height_ff;
      if (height_ff < DIM_MIN) eff_h = DIM_MIN;
      else if (height_ff > HEIGHT_TOP) eff_h = HEIGHT_TOP;
   end

   assign area_prod = eff_w * eff_h;
   assign area_in   = CNT_W'(area_prod - 24'd1);

   always_comb begin
      wrap   = CFG_W'(col_ff) >= eff_w;
      c      = wrap ? '0 : col_ff;
      r      = (wrap && row_ff != ROW_SAT) ? row_ff + 12'd1 : row_ff;
      c_ext  = CFG_W'(c);
      c_next = c_ext + 12'd1;
      wrap2  = c_next >= eff_w;
      r_next = (wrap2 && r != ROW_SAT) ? r + 12'd1 : r;
      emit   = (r >= 12'd2) || (r == 12'd1 && c_ext != '0);
      if (c_ext == '0) begin
         ocol = eff_w - 12'd1;
         orow = r - 12'd2;
      end else begin
         ocol = c_ext - 12'd1;
         orow = r - 12'd1;
      end
      border = (orow == '0) || (orow >= eff_h - 12'd1) ||
               (ocol == '0) || (ocol >= eff_w - 12'd1);
      fe     = emit && (cnt_ff >= area_ff);

      col_in = col_ff;
      row_in = row_ff;
      cnt_in = cnt_ff;
      if (accept) begin
         if (fe) begin
            col_in = '0;
            row_in = '0;
            cnt_in = '0;
         end else begin
            col_in = wrap2 ? '0 : c_next[AW-1:0];
            row_in = r_next;
            cnt_in = emit ? cnt_ff + 22'd1 : cnt_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         busy_ff   <= 1'b0;
         col_ff    <= '0;
         row_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         busy_ff <= csr_wr_en;
         if (csr_wr_en) begin
            if (csr_index == CSR_IDX_WIDTH) width_ff <= csr_wdata;
            else height_ff <= csr_wdata;
         end
         col_ff <= col_in;
         row_ff <= row_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      area_ff <= area_in;
   end

   assign col            = c;
   assign info.emit      = emit;
   assign info.border    = border;
   assign info.frame_end = fe;
   assign cfg_busy       = busy_ff;

endmodule

FILE: rtl/rbb_window.sv
// ----------------------------------------------------------------------------
// rbb_window
// 3x3 pixel window; per-channel neighborhood sums and the center pixel.
// ----------------------------------------------------------------------------
module rbb_window (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      shift_en,
   input  logic [rbb_pkg::PIX_W-1:0] upper_px,
   input  logic [rbb_pkg::PIX_W-1:0] middle_px,
   input  logic [rbb_pkg::PIX_W-1:0] lower_px,
   output logic [rbb_pkg::PIX_W-1:0] center,
   output rbb_pkg::sum_vec_type      sums
);
   import rbb_pkg::*;

   logic [PIX_W-1:0] win_ff [9];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 9; k++) win_ff[k] <= '0;
      end else if (shift_en) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]   <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= upper_px;
         win_ff[5] <= middle_px;
         win_ff[8] <= lower_px;
      end
   end

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sums[ch] = '0;
         for (int k = 0; k < 9; k++) begin
            sums[ch] = sums[ch] + SUM_W'(win_ff[k][ch*CH_W +: CH_W]);
         end
      end
   end

   assign center = win_ff[4];

endmodule

FILE: dv/testbench.sv
// ---------------------------------------------------------------------------
// rgb_box_blur_3x3 testbench
// Streams RGB frames through the 3x3 box blur and compares every output pixel
// with a built-in prediction of the line buffers, window and border handling.
// Covers clamped and extreme frame sizes, flush items inside frames, pixels
// during the flush phase, short and long flush tails, and size changes
// mid-frame. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rbb_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 400;
   localparam int unsigned QUIET_ITEMS  = 100;
   localparam int unsigned DRAIN_CYCLES = 32;
   localparam int unsigned CYCLE_LIMIT  = 2_500_000;
   localparam int unsigned EDGE_ITEMS   = 60;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } blur_pixel_type;

   class blur_scoreboard;
      logic [CFG_W-1:0] width_reg;
      logic [CFG_W-1:0] height_reg;
      logic [PIX_W-1:0] upper_row [DIM_MAX];
      logic [PIX_W-1:0] middle_row [DIM_MAX];
      logic [PIX_W-1:0] window [9];
      int unsigned      column;
      int unsigned      row;
      int unsigned      out_pixels;
      blur_pixel_type   blurred_q[$];
      int unsigned      errors;

      function new();
         width_reg  = WIDTH_RST;
         height_reg = HEIGHT_RST;
         foreach (upper_row[i]) upper_row[i] = '0;
         foreach (middle_row[i]) middle_row[i] = '0;
         foreach (window[i]) window[i] = '0;
         column     = 0;
         row        = 0;
         out_pixels = 0;
         errors     = 0;
      endfunction

      function void write_reg(logic [0:0] index, logic [CFG_W-1:0] value);
         if (index == CSR_IDX_WIDTH) width_reg = value;
         else if (index == CSR_IDX_HEIGHT) height_reg = value;
      endfunction

      function int unsigned eff_width();
         int unsigned w;
         w = width_reg;
         if (w < DIM_MIN) w = DIM_MIN;
         if (w > DIM_MAX) w = DIM_MAX;
         return w;
      endfunction

      function int unsigned eff_height();
         int unsigned h;
         h = height_reg;
         if (h < DIM_MIN) h = DIM_MIN;
         if (h > HEIGHT_TOP) h = HEIGHT_TOP;
         return h;
      endfunction

      function int unsigned pending();
         return blurred_q.size();
      endfunction

      function void next_row();
         column = 0;
         if (row < ROW_SAT) row++;
      endfunction

      // one accepted request: advance the scan, maybe predict one output pixel
      function void take_request(logic [PIX_W-1:0] data, logic flush);
         int unsigned    w, h, c, r, ocol, orow, total;
         logic [PIX_W-1:0] px, res;
         blur_pixel_type want;
         w  = eff_width();
         h  = eff_height();
         px = flush ? '0 : data;
         if (column >= w) next_row();
         c = column;
         r = row;
         for (int k = 0; k < 3; k++) begin
            window[k*3]   = window[k*3+1];
            window[k*3+1] = window[k*3+2];
         end
         window[2]     = upper_row[c];
         window[5]     = middle_row[c];
         upper_row[c]  = middle_row[c];
         middle_row[c] = px;
         window[8]     = px;
         column++;
         if (column >= w) next_row();
         if (!(r >= 2 || (r == 1 && c >= 1))) return;

         if (c == 0) begin
            ocol = w - 1;
            orow = r - 2;
         end else begin
            ocol = c - 1;
            orow = r - 1;
         end
         if (orow == 0 || orow >= h - 1 || ocol == 0 || ocol >= w - 1) begin
            res = window[4];
         end else begin
            for (int ch = 0; ch < 3; ch++) begin
               total = 0;
               for (int k = 0; k < 9; k++) total += window[k][ch*CH_W +: CH_W];
               res[ch*CH_W +: CH_W] = CH_W'(total / 9);
            end
         end
         want.blue      = res[7:0];
         want.green     = res[15:8];
         want.red       = res[23:16];
         want.frame_end = 1'b0;
         if (out_pixels >= w * h - 1) begin
            want.frame_end = 1'b1;
            column         = 0;
            row            = 0;
            out_pixels     = 0;
         end else begin
            out_pixels = (out_pixels + 1) & 32'h3F_FFFF;
         end
         blurred_q.push_back(want);
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $error("%s: expected %0d, actual %0d", name, want, got);
         end
      endfunction

      function void check_result(logic [PIX_W-1:0] data, logic last);
         blur_pixel_type want;
         if (blurred_q.size() == 0) begin
            errors++;
            $error("output pixel with none expected: blue %0d green %0d red %0d frame_end %0d",
                   data[7:0], data[15:8], data[23:16], last);
            return;
         end
         want = blurred_q.pop_front();
         compare_field("out_blue", want.blue, data[7:0]);
         compare_field("out_green", want.green, data[15:8]);
         compare_field("out_red", want.red, data[23:16]);
         compare_field("frame_end", want.frame_end, last);
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_wr_en;
   logic [0:0]       csr_index;
   logic [CFG_W-1:0] csr_wdata;
   logic             req_tvalid;
   logic             req_tready;
   logic [PIX_W-1:0] req_tdata;   // blue, green, red
   logic             req_tuser;   // flush
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [PIX_W-1:0] rsp_tdata;   // blue, green, red
   logic             rsp_tlast;   // frame end

   blur_scoreboard sb;
   bit             quiet;
   int unsigned    sent_count;
   int unsigned    cycle_count;

   rgb_box_blur_3x3 dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("** rgb_box_blur_3x3: FAILED **");
      $finish;
   end

   // results are checked before the same edge's request is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tlast);
         if (req_tvalid && req_tready) sb.take_request(req_tdata, req_tuser);
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] p;
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 7))
            0: p[ch*CH_W +: CH_W] = 8'h00;
            1: p[ch*CH_W +: CH_W] = 8'hFF;
            default: p[ch*CH_W +: CH_W] = 8'($urandom);
         endcase
      end
      return p;
   endfunction

   // entered and left at a falling edge
   task automatic send_request(logic [PIX_W-1:0] data, logic flush);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= flush;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [0:0] index, logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_reg(index, value);
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_size(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
      write_reg(CSR_IDX_WIDTH, w);
      write_reg(CSR_IDX_HEIGHT, h);
   endtask

   // one frame with noise; a cut frame stops partway and leaves no tail
   task automatic run_frame(bit cut);
      int unsigned w, h, stop, tail;
      w    = sb.eff_width();
      h    = sb.eff_height();
      stop = cut ? $urandom_range(1, w * h - 1) : w * h;
      for (int unsigned i = 0; i < stop; i++)
         send_request(rand_pixel(), $urandom_range(0, 24) == 0);
      if (cut) return;
      tail = w + 1;
      case ($urandom_range(0, 7))
         0: tail += $urandom_range(1, 3);
         1: tail -= $urandom_range(1, w);
         default: ;
      endcase
      for (int unsigned i = 0; i < tail; i++)
         send_request(rand_pixel(), $urandom_range(0, 9) != 0);
   endtask

   initial begin
      logic [PIX_W-1:0] px;
      int unsigned      base;
      bit               cut;
      sb          = new();
      quiet       = 1'b0;
      sent_count  = 0;
      cycle_count = 0;
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_index   = '0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      rsp_tready  = 1'b0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sizes below the minimum clamp to 3x3
      set_size(12'd2, 12'd0);

      // all-white frame: largest sums
      for (int i = 0; i < 9; i++) send_request(24'hFF_FFFF, 1'b0);
      for (int i = 0; i < 4; i++) send_request(24'h00_0000, 1'b1);

      // mixed frame, flush as black center, pixel in flush phase, extra flushes
      for (int i = 0; i < 9; i++) begin
         px = {8'hFF - 8'(i * 31), 8'(1 + i), 8'h80 ^ 8'(i * 17)};
         send_request(px, i == 4);
      end
      send_request(24'h5A_A55A, 1'b1);
      send_request(24'hAB_CDEF, 1'b0);
      send_request(24'hFF_FFFF, 1'b1);
      send_request(24'h00_0000, 1'b1);
      send_request(24'hFF_FFFF, 1'b1);
      send_request(24'h12_3456, 1'b1);

      // widest and tallest sizes, written with all-ones values, partial frames
      drain();
      set_size(12'd4095, 12'd3);
      for (int i = 0; i < EDGE_ITEMS; i++) send_request(rand_pixel(), 1'b0);
      drain();
      set_size(12'd3, 12'd4095);
      for (int i = 0; i < EDGE_ITEMS; i++) send_request(rand_pixel(), 1'b0);
      drain();
      set_size(12'd5, 12'd4);

      base = sent_count;
      while (sent_count - base < RANDOM_ITEMS) begin
         if (sent_count - base >= RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
         cut = ($urandom_range(0, 5) == 0);
         run_frame(cut);
         if (cut || $urandom_range(0, 2) == 0) begin
            drain();
            case ($urandom_range(0, 2))
               0: write_reg(CSR_IDX_WIDTH, 12'($urandom_range(0, 16)));
               1: write_reg(CSR_IDX_HEIGHT, 12'($urandom_range(0, 10)));
               default: set_size(12'($urandom_range(0, 16)), 12'($urandom_range(0, 10)));
            endcase
         end
      end
      drain();

      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("** rgb_box_blur_3x3: PASSED **");
      end else begin
         $display("** rgb_box_blur_3x3: FAILED **");
      end
      $finish;
   end

endmodule
